>>> sv/hff_pkg.sv
package hff_pkg;

   // count width: holds any field width or precision up to 63
   localparam int CNT_W = 6;
   // digit count of a 32-bit value, 1 to 8
   localparam int LEN_W = 4;
   // descriptor queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // register indexes on the csr port
   localparam logic [2:0] REG_UPPER_CASE   = 3'd0;
   localparam logic [2:0] REG_ALT_FORM     = 3'd1;
   localparam logic [2:0] REG_LEFT_JUSTIFY = 3'd2;
   localparam logic [2:0] REG_ZERO_PAD     = 3'd3;
   localparam logic [2:0] REG_FIELD_WIDTH  = 3'd4;
   localparam logic [2:0] REG_MIN_DIGITS   = 3'd5;

   // ascii codes
   localparam logic [7:0] CHR_ZERO     = 8'd48;
   localparam logic [7:0] CHR_SPACE    = 8'd32;
   localparam logic [7:0] CHR_X_LOWER  = 8'd120;
   localparam logic [7:0] CHR_X_UPPER  = 8'd88;
   localparam logic [7:0] ALPHA_OFS_LO = 8'd87;
   localparam logic [7:0] ALPHA_OFS_UP = 8'd55;

   typedef struct packed {
      logic             upper_case;
      logic             alt_form;
      logic             left_justify;
      logic             zero_pad;
      logic [CNT_W-1:0] field_width;
      logic [CNT_W-1:0] min_digits;
   } cfg_type;

   // one classified item, as handed from front to back
   typedef struct packed {
      logic [31:0]      value;
      logic [LEN_W-1:0] len;
      logic [CNT_W-1:0] prec_cnt;
      logic [CNT_W-1:0] pad_cnt;
      logic             prefix;
      logic             upper_case;
      logic             left_justify;
      logic             zero_pad;
   } desc_type;

   // ascii character of one hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CHR_ZERO + {4'd0, nib};
      end else begin
         ch = {4'd0, nib} + (upper ? ALPHA_OFS_UP : ALPHA_OFS_LO);
      end
      return ch;
   endfunction

endpackage

>>> sv/hff_front.sv
module hff_front #(
   parameter int MAX_FIELD = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  hff_pkg::cfg_type  cfg,
   input  logic              req_push,
   output logic              req_full,
   input  logic [31:0]       req_value,
   output logic              q_push,
   input  logic              q_full,
   output hff_pkg::desc_type q_data
);
   import hff_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELD);

   logic              valid_ff, valid_in;
   desc_type          desc_ff, desc_in;
   logic [CNT_W-1:0]  width_sat, prec_sat, body_len;
   logic [LEN_W-1:0]  len;
   logic              zero_alt, accept;

   // saturate the field registers
   assign width_sat = (cfg.field_width > MAX_CNT) ? MAX_CNT : cfg.field_width;
   assign prec_sat  = (cfg.min_digits > MAX_CNT) ? MAX_CNT : cfg.min_digits;

   // significant digit count
   always_comb begin
      len = LEN_W'(1);
      for (int i = 1; i < 8; i++) begin
         if ((req_value >> (4 * i)) != 32'd0) begin
            len = LEN_W'(i + 1);
         end
      end
   end

   // digits plus precision zeros
   assign body_len = (prec_sat > CNT_W'(len)) ? prec_sat : CNT_W'(len);
   assign zero_alt = cfg.alt_form && (req_value == 32'd0);

   // classify the beat into a descriptor
   always_comb begin
      desc_in              = desc_ff;
      desc_in.value        = req_value;
      desc_in.len          = len;
      desc_in.prec_cnt     = zero_alt ? '0 : body_len - CNT_W'(len);
      desc_in.pad_cnt      = (zero_alt || width_sat <= body_len) ? '0 : width_sat - body_len;
      desc_in.prefix       = cfg.alt_form && (req_value != 32'd0);
      desc_in.upper_case   = cfg.upper_case;
      desc_in.left_justify = cfg.left_justify;
      desc_in.zero_pad     = cfg.zero_pad;
   end

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff;
   assign q_data   = desc_ff;

   // stage register in front of the queue
   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !q_full) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

>>> sv/hff_queue.sv
module hff_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  hff_pkg::desc_type wdata,
   input  logic              pop,
   output logic              empty,
   output hff_pkg::desc_type rdata
);
   import hff_pkg::*;

   desc_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   // pointer and fill count
   always_comb begin
      wptr_in  = do_push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

>>> sv/hff_back.sv
module hff_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  hff_pkg::desc_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_char
);
   import hff_pkg::*;

   // output sections, in emission order
   localparam logic [2:0] PH_LEAD  = 3'd0;
   localparam logic [2:0] PH_PFX   = 3'd1;
   localparam logic [2:0] PH_ZPAD  = 3'd2;
   localparam logic [2:0] PH_PREC  = 3'd3;
   localparam logic [2:0] PH_DIG   = 3'd4;
   localparam logic [2:0] PH_TRAIL = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   logic              busy_ff, busy_in;
   logic [2:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   desc_type          desc_ff;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              advance, last, load;
   logic [2:0]        nxt_phase, ld_phase, dig_idx;

   // characters in one section
   function automatic logic [CNT_W-1:0] sec_count(input logic [2:0] ph, input desc_type d);
      logic [CNT_W-1:0] n;
      case (ph)
         PH_LEAD:  n = (!d.zero_pad && !d.left_justify) ? d.pad_cnt : '0;
         PH_PFX:   n = d.prefix ? CNT_W'(2) : '0;
         PH_ZPAD:  n = d.zero_pad ? d.pad_cnt : '0;
         PH_PREC:  n = d.prec_cnt;
         PH_DIG:   n = CNT_W'(d.len);
         PH_TRAIL: n = (!d.zero_pad && d.left_justify) ? d.pad_cnt : '0;
         default:  n = '0;
      endcase
      return n;
   endfunction

   // first non-empty section at or after start
   function automatic logic [2:0] pick(input logic [2:0] start, input desc_type d);
      logic [2:0] ph;
      logic       found;
      ph    = PH_DONE;
      found = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (!found && 3'(k) >= start && sec_count(3'(k), d) != '0) begin
            ph    = 3'(k);
            found = 1'b1;
         end
      end
      return ph;
   endfunction

   assign advance   = busy_ff && (!out_valid_ff || rsp_pop);
   assign nxt_phase = pick(phase_ff + 3'd1, desc_ff);
   assign last      = (cnt_ff == CNT_W'(1)) && (nxt_phase == PH_DONE);
   assign load      = !q_empty && (!busy_ff || (advance && last));
   assign q_pop     = load;
   assign ld_phase  = pick(PH_LEAD, q_data);
   assign dig_idx   = cnt_ff[2:0] - 3'd1;

   // character of the current position
   always_comb begin
      case (phase_ff)
         PH_LEAD, PH_TRAIL: out_char_in = CHR_SPACE;
         PH_PFX: begin
            if (cnt_ff == CNT_W'(2)) begin
               out_char_in = CHR_ZERO;
            end else begin
               out_char_in = desc_ff.upper_case ? CHR_X_UPPER : CHR_X_LOWER;
            end
         end
         PH_DIG:  out_char_in = hex_char(desc_ff.value[4*dig_idx +: 4], desc_ff.upper_case);
         default: out_char_in = CHR_ZERO;
      endcase
   end

   // sequencer and output register
   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_last_in  = last;
         if (last) begin
            busy_in = 1'b0;
         end else if (cnt_ff == CNT_W'(1)) begin
            phase_in = nxt_phase;
            cnt_in   = sec_count(nxt_phase, desc_ff);
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         phase_in = ld_phase;
         cnt_in   = sec_count(ld_phase, q_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_DONE;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
      end
      if (load) begin
         desc_ff <= q_data;
      end
      if (advance) begin
         out_char_ff <= out_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

>>> sv/hex_field_formatter_core.sv
// Hexadecimal field formatter: turns each 32-bit value into printf-style hex
// text, one ASCII character per result beat, last character flagged.
// Input channel: req_push / req_full carry req_value; a beat is taken when
// req_push is high and req_full low. Result channel: rsp_out_char and
// rsp_last_char are valid while rsp_empty is low; rsp_pop takes a beat.
// csr port: six registers at byte addresses 0,4,..,20 (upper_case, alt_form,
// left_justify, zero_pad, field_width, min_digits); write only while idle.
// The first character of a value passes the front stage, the descriptor queue,
// the back's descriptor register and the output register, in that order.
// Throughput: one character per cycle from the back sequencer while the
// receiver pops; a field has 1 to MAX_FIELD+2 characters. A queued next
// value's first character follows the previous last with no gap.
// When the receiver stalls, the output register holds its beat, the back
// stops, the two-entry queue fills and then req_full rises.
// Reset clears the registers to zero and empties all stages.
module hex_field_formatter_core #(
   parameter int MAX_FIELD = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hff_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;
   logic       q_push, q_full, q_pop, q_empty;
   desc_type   q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_UPPER_CASE:   cfg_in.upper_case   = csr_pwdata[0];
            REG_ALT_FORM:     cfg_in.alt_form     = csr_pwdata[0];
            REG_LEFT_JUSTIFY: cfg_in.left_justify = csr_pwdata[0];
            REG_ZERO_PAD:     cfg_in.zero_pad     = csr_pwdata[0];
            REG_FIELD_WIDTH:  cfg_in.field_width  = csr_pwdata[CNT_W-1:0];
            REG_MIN_DIGITS:   cfg_in.min_digits   = csr_pwdata[CNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         REG_UPPER_CASE:   csr_prdata = {31'd0, cfg_ff.upper_case};
         REG_ALT_FORM:     csr_prdata = {31'd0, cfg_ff.alt_form};
         REG_LEFT_JUSTIFY: csr_prdata = {31'd0, cfg_ff.left_justify};
         REG_ZERO_PAD:     csr_prdata = {31'd0, cfg_ff.zero_pad};
         REG_FIELD_WIDTH:  csr_prdata = {(32-CNT_W)'(0), cfg_ff.field_width};
         REG_MIN_DIGITS:   csr_prdata = {(32-CNT_W)'(0), cfg_ff.min_digits};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hff_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_data    (q_wdata)
   );

   hff_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .wdata (q_wdata),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   hff_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hff_pkg::*;

   localparam int MAX_FIELD      = 48;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 17;

   // one expected character beat
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_beat_type;

   // expected text of every accepted value, checked in order
   class hex_text_scoreboard;
      cfg_type       fmt;
      text_beat_type expected_text[$];
      int            n_errors;
      int            n_checked;

      function new();
         fmt       = '0;
         n_errors  = 0;
         n_checked = 0;
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         n_errors++;
      endtask

      // shadow copy of the csr registers, masked as the block keeps them
      function void set_register(input logic [2:0] idx, input logic [31:0] data);
         case (idx)
            REG_UPPER_CASE:   fmt.upper_case   = data[0];
            REG_ALT_FORM:     fmt.alt_form     = data[0];
            REG_LEFT_JUSTIFY: fmt.left_justify = data[0];
            REG_ZERO_PAD:     fmt.zero_pad     = data[0];
            REG_FIELD_WIDTH:  fmt.field_width  = data[CNT_W-1:0];
            REG_MIN_DIGITS:   fmt.min_digits   = data[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // build the formatted field of one accepted value
      function void note_value(input logic [31:0] v);
         logic [7:0]    chars[$];
         logic [3:0]    nib;
         int unsigned   len, p, w, width, prec, i;
         text_beat_type beat;
         // zero in alternate form is a lone digit, width and precision ignored
         if (v == 32'd0 && fmt.alt_form) begin
            beat.code = CHR_ZERO;
            beat.last = 1'b1;
            expected_text.push_back(beat);
            return;
         end
         len = 1;
         while (len < 8 && (v >> (4 * len)) != 32'd0) len++;
         width = (fmt.field_width > MAX_FIELD) ? MAX_FIELD : fmt.field_width;
         prec  = (fmt.min_digits > MAX_FIELD) ? MAX_FIELD : fmt.min_digits;
         p = (prec > len) ? prec - len : 0;
         w = (width > len + p) ? width - len - p : 0;
         // leading spaces, right justified only
         if (!fmt.zero_pad && !fmt.left_justify)
            for (i = 0; i < w; i++) chars.push_back(CHR_SPACE);
         if (fmt.alt_form) begin
            chars.push_back(CHR_ZERO);
            chars.push_back(fmt.upper_case ? CHR_X_UPPER : CHR_X_LOWER);
         end
         // zero padding sits after the prefix
         if (fmt.zero_pad)
            for (i = 0; i < w; i++) chars.push_back(CHR_ZERO);
         for (i = 0; i < p; i++) chars.push_back(CHR_ZERO);
         for (i = len; i > 0; i--) begin
            nib = v[4*(i-1) +: 4];
            if (nib < 4'd10) chars.push_back(CHR_ZERO + {4'd0, nib});
            else chars.push_back({4'd0, nib} + (fmt.upper_case ? ALPHA_OFS_UP : ALPHA_OFS_LO));
         end
         // trailing spaces, left justified only
         if (!fmt.zero_pad && fmt.left_justify)
            for (i = 0; i < w; i++) chars.push_back(CHR_SPACE);
         foreach (chars[k]) begin
            beat.code = chars[k];
            beat.last = (k == chars.size() - 1);
            expected_text.push_back(beat);
         end
      endfunction

      // compare one accepted result beat with the oldest expectation
      task check_char(input logic [7:0] code, input logic last);
         text_beat_type want;
         if (expected_text.size() == 0) begin
            report($sformatf("beat %0d: unexpected char 0x%02h last %0b", n_checked, code, last));
         end else begin
            want = expected_text.pop_front();
            if (code !== want.code)
               report($sformatf("beat %0d: char 0x%02h, expected 0x%02h",
                                n_checked, code, want.code));
            if (last !== want.last)
               report($sformatf("beat %0d: last %0b, expected %0b",
                                n_checked, last, want.last));
         end
         n_checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [31:0] req_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hex_text_scoreboard sb;
   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_request;
   int stall_cycles;

   hex_field_formatter_core #(
      .MAX_FIELD (MAX_FIELD)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accepted beats on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_value(req_value);
         if (rsp_pop && !rsp_empty) sb.check_char(rsp_out_char, rsp_last_char);
      end
   end

   // watchdog on cycles with no beat accepted anywhere
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold on request
   initial begin
      rsp_pop = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   // one register write, setup then access
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // write all six registers, unused upper bits filled with noise
   task automatic apply_format(input bit u, input bit a, input bit l, input bit z,
                               input logic [5:0] fw, input logic [5:0] md);
      write_reg(REG_UPPER_CASE,   ($urandom() & ~32'h1) | u);
      write_reg(REG_ALT_FORM,     ($urandom() & ~32'h1) | a);
      write_reg(REG_LEFT_JUSTIFY, ($urandom() & ~32'h1) | l);
      write_reg(REG_ZERO_PAD,     ($urandom() & ~32'h1) | z);
      write_reg(REG_FIELD_WIDTH,  ($urandom() & ~32'h3f) | fw);
      write_reg(REG_MIN_DIGITS,   ($urandom() & ~32'h3f) | md);
   endtask

   // offer one value and wait for its beat; push stays high unless a gap follows
   task automatic send_value(input logic [31:0] v);
      @(negedge clock);
      req_push  = 1'b1;
      req_value = v;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_push  = 1'b0;
         req_value = $urandom();
         repeat ($urandom_range(1, 17) - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait until the whole text has come out
   task automatic drain_results();
      @(negedge clock);
      req_push = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // counts lean small, with the extremes and oversized values now and then
   function automatic logic [5:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 6'd0;
         1: return 6'd48;
         2: return 6'($urandom_range(49, 63));
         3: return 6'($urandom_range(0, 63));
         default: return 6'($urandom_range(0, 12));
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0, 1: return 32'd0;
         2:    return 32'hffff_ffff;
         3, 4: return $urandom();
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   // stimulus
   initial begin
      sb           = new();
      reset        = 1'b1;
      req_push     = 1'b0;
      req_value    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      tx_idle_on   = 1'b1;
      rx_idle_on   = 1'b1;
      hold_request = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset values, nothing written yet
      send_value(32'd0);
      send_value(32'hffff_ffff);
      send_value(32'd1);
      send_value(32'h9);
      send_value(32'ha);
      send_value(32'hf);
      send_value(32'h10);
      send_value(32'h8000_0000);
      drain_results();

      // alternate form upper case, zero alone, right justified
      apply_format(1, 1, 0, 0, 6'd10, 6'd0);
      send_value(32'd0);
      send_value(32'hdead_beef);
      send_value(32'hab);
      drain_results();

      // zero pad after prefix, then precision zeros
      apply_format(0, 1, 0, 1, 6'd12, 6'd4);
      send_value(32'h1f);
      send_value(32'd0);
      send_value(32'h1234_5678);
      drain_results();

      // largest width and precision, left justified
      apply_format(0, 0, 1, 0, 6'd48, 6'd48);
      send_value(32'h5);
      send_value(32'hffff_ffff);
      drain_results();

      // oversized counts saturate, zero pad wins over left justify
      apply_format(1, 0, 1, 1, 6'd63, 6'd63);
      send_value(32'h3);
      send_value(32'hc0_ffee);
      drain_results();

      // alternate zero ignores width; prefix with trailing spaces
      apply_format(0, 1, 1, 0, 6'd20, 6'd6);
      send_value(32'd0);
      send_value(32'h7);
      drain_results();

      // plain zero takes width without alternate form
      apply_format(0, 0, 0, 0, 6'd5, 6'd0);
      send_value(32'd0);
      send_value(32'hffff);
      drain_results();

      // zero value still gets precision zeros
      apply_format(0, 0, 0, 1, 6'd0, 6'd3);
      send_value(32'd0);
      send_value(32'habc);
      drain_results();

      // random formats and values
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_format(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_count(), pick_count());
         if (ph == RANDOM_PHASES - 1) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         // receiver holds off while the sender keeps offering, filling the block
         if (ph == 2) begin
            hold_request = 1'b1;
            tx_idle_on   = 1'b0;
            for (int k = 0; k < 12; k++) send_value(pick_value());
            tx_idle_on   = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) send_value(pick_value());
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
